// File: rtl/core/assert_macros.svh
// assertion macros shared by the weighted deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define WDQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("weighted deque assertion failed");

// same-cycle implication
`define WDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted deque assertion failed");

// next-cycle implication
`define WDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted deque assertion failed");

`endif

// File: rtl/core/wdq_pkg.sv
// types, codes and constants shared by the weighted deque modules
`default_nettype none

package wdq_pkg;

    // default configuration
    localparam int WDQ_DEPTH_DEF   = 64;
    localparam int WDQ_VALUE_W_DEF = 16;

    // fixed beat field widths
    localparam int WDQ_KIND_W  = 2;
    localparam int WDQ_VALUE_W = 16;
    localparam int WDQ_POP_W   = 16;
    localparam int WDQ_WSUM_W  = 28;
    localparam int WDQ_COUNT_W = 7;

    // operation codes
    localparam logic [WDQ_KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [WDQ_KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
    localparam logic [WDQ_KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [WDQ_KIND_W-1:0] KIND_POP_REAR   = 2'd3;

    typedef struct packed {
        logic [WDQ_KIND_W-1:0]         kind;
        logic signed [WDQ_VALUE_W-1:0] value;
    } t_wdq_in;

    typedef struct packed {
        logic signed [WDQ_POP_W-1:0]  popped_value;
        logic signed [WDQ_WSUM_W-1:0] weighted_sum;
        logic [WDQ_COUNT_W-1:0]       entry_count;
        logic                         is_empty;
        logic                         error_flag;
    } t_wdq_out;

    // controller to datapath commands
    typedef struct packed {
        logic accept;   // latch input beat, launch memory read
        logic calc;     // pick operand, registered multiply
        logic update;   // commit state, load result register
    } t_wdq_cmd;

endpackage

`default_nettype wire

// File: rtl/core/weighted_deque.sv
// weighted_deque: bounded double-ended queue with a running position-weighted sum
//
// input channel: i_in_valid / o_in_stall with one t_wdq_in beat (kind, value);
// kind selects push front, push rear, pop front or pop rear
// output channel: o_out_valid / i_out_stall with one t_wdq_out beat per input
// beat: popped value, weighted sum, entry count, empty flag, error flag
// a beat moves at a rising edge where valid is high and stall is low
// an input beat and its ring memory read are registered in the idle state,
// its operand and product in the calc state, and the update state commits
// the state and loads the result register before another input beat is taken
// the result register parts the two sides: a new input beat is taken while an
// earlier result still waits, and the update stage holds until that slot frees
// a stalled receiver therefore holds the block after one more beat at most
// pop on empty and push on full leave the state alone and raise the error flag
// reset (synchronous, active low) empties the queue and clears both sums;
// memory contents are not cleared; a slot read before it is written is never used
`default_nettype none

module weighted_deque
    import wdq_pkg::*;
#(
    parameter int DEPTH       = WDQ_DEPTH_DEF,
    parameter int VALUE_WIDTH = WDQ_VALUE_W_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // input beats
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_wdq_in i_in_data,
    // result beats
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_wdq_out     o_out_data
);

    // sequencing commands from controller to datapath
    t_wdq_cmd cmd;

    // controller: idle, operand/multiply, update-and-show
    wdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath: ring memory, head and count, plain and weighted sums
    wdq_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in_data),
        .o_out   (o_out_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/wdq_ctrl.sv
// sequencing state machine and result-valid register of the weighted deque
`default_nettype none
`include "assert_macros.svh"

module wdq_ctrl
    import wdq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_wdq_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // result register can take a new beat at this edge
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.update ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `WDQ_ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n, $onehot0(o_cmd))
    `WDQ_ASSERT_NEXT(a_accept_to_calc, i_clk, i_rst_n, o_cmd.accept, r_state == S_CALC)
    `WDQ_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.update, !(r_out_valid && i_out_stall))
    `WDQ_ASSERT_NEXT(a_update_shows, i_clk, i_rst_n, o_cmd.update, r_out_valid)

endmodule

`default_nettype wire

// File: rtl/core/wdq_dpath.sv
// ring memory, pointers, running sums and result register of the weighted deque
`default_nettype none
`include "assert_macros.svh"

module wdq_dpath
    import wdq_pkg::*;
#(
    parameter int DEPTH       = WDQ_DEPTH_DEF,
    parameter int VALUE_WIDTH = WDQ_VALUE_W_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_wdq_cmd i_cmd,
    input  wire t_wdq_in  i_in,
    output t_wdq_out      o_out
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_IW = IDX_W + 1;
    localparam int PSUM_W = (VALUE_WIDTH + CNT_W < WDQ_WSUM_W) ?
                            (VALUE_WIDTH + CNT_W) : WDQ_WSUM_W;
    localparam int RAW_W  = (VALUE_WIDTH > WDQ_VALUE_W) ? VALUE_WIDTH : WDQ_VALUE_W;
    localparam int PROD_W = CNT_W + 1 + VALUE_WIDTH;
    localparam int CNTO_W = (CNT_W > WDQ_COUNT_W) ? CNT_W : WDQ_COUNT_W;

    localparam logic [SUM_IW-1:0] DEPTH_S  = SUM_IW'(DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    // ring storage, no reset
    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];

    // architectural state
    logic [IDX_W-1:0]               r_head;
    logic [CNT_W-1:0]               r_count;
    logic signed [PSUM_W-1:0]       r_psum;
    logic signed [WDQ_WSUM_W-1:0]   r_wsum;

    // per-beat registers
    logic [WDQ_KIND_W-1:0]          r_kind;
    logic signed [VALUE_WIDTH-1:0]  r_val;
    logic                           r_err;
    logic [IDX_W-1:0]               r_slot;
    logic signed [VALUE_WIDTH-1:0]  r_rdata;
    logic signed [VALUE_WIDTH-1:0]  r_opnd;
    logic signed [WDQ_WSUM_W-1:0]   r_prod;
    t_wdq_out                       r_out;

    // input decode
    logic [RAW_W-1:0]               in_raw;
    logic signed [VALUE_WIDTH-1:0]  in_val;
    logic                           in_is_push;
    logic                           in_err;
    logic [IDX_W-1:0]               head_prev;
    logic [SUM_IW-1:0]              tail_sum;
    logic [SUM_IW-1:0]              rear_raw;
    logic [IDX_W-1:0]               rear_slot;
    logic [IDX_W-1:0]               in_slot;

    assign in_raw     = RAW_W'(unsigned'(i_in.value));
    assign in_val     = in_raw[VALUE_WIDTH-1:0];
    assign in_is_push = (i_in.kind == KIND_PUSH_FRONT) || (i_in.kind == KIND_PUSH_REAR);
    assign in_err     = in_is_push ? (r_count == FULL_CNT) : (r_count == '0);
    assign head_prev  = (r_head == '0) ? LAST_IDX : (r_head - IDX_W'(1));
    assign tail_sum   = SUM_IW'(r_head) + SUM_IW'(r_count);
    assign rear_raw   = (i_in.kind == KIND_POP_REAR) ? (tail_sum - SUM_IW'(1)) : tail_sum;
    assign rear_slot  = (rear_raw >= DEPTH_S) ? IDX_W'(rear_raw - DEPTH_S)
                                              : IDX_W'(rear_raw);

    always_comb begin
        case (i_in.kind) inside
            KIND_PUSH_FRONT:               in_slot = head_prev;
            KIND_POP_FRONT:                in_slot = r_head;
            KIND_PUSH_REAR, KIND_POP_REAR: in_slot = rear_slot;
            default:                       in_slot = r_head;
        endcase
    end

    // operand select and multiply
    logic                           is_pop;
    logic signed [VALUE_WIDTH-1:0]  opnd;
    logic [CNT_W-1:0]               mul_k;
    logic signed [PROD_W-1:0]       mul_a;
    logic signed [PROD_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]       mul_p;

    assign is_pop   = (r_kind == KIND_POP_FRONT) || (r_kind == KIND_POP_REAR);
    assign opnd     = is_pop ? r_rdata : r_val;
    // rear push weighs the new entry by the count after the push
    assign mul_k    = (r_kind == KIND_PUSH_REAR) ? (r_count + CNT_W'(1)) : r_count;
    assign mul_a    = signed'(PROD_W'(mul_k));
    assign mul_b    = PROD_W'(opnd);
    assign mul_p    = mul_a * mul_b;

    // state update
    logic [IDX_W-1:0]               n_head;
    logic [CNT_W-1:0]               n_count;
    logic signed [PSUM_W-1:0]       n_psum;
    logic signed [WDQ_WSUM_W-1:0]   n_wsum;
    logic signed [PSUM_W-1:0]       opnd_p;
    logic signed [WDQ_WSUM_W-1:0]   opnd_w;
    logic signed [WDQ_WSUM_W-1:0]   psum_w;
    logic signed [VALUE_WIDTH-1:0]  pop_sel;
    logic signed [RAW_W-1:0]        pop_wide;
    logic [CNTO_W-1:0]              cnt_wide;

    assign opnd_p = PSUM_W'(r_opnd);
    assign opnd_w = WDQ_WSUM_W'(r_opnd);
    assign psum_w = WDQ_WSUM_W'(r_psum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_psum  = r_psum;
        n_wsum  = r_wsum;
        if (!r_err) begin
            case (r_kind)
                KIND_PUSH_FRONT: begin
                    // every old entry moves back one place
                    n_head  = r_slot;
                    n_count = r_count + CNT_W'(1);
                    n_psum  = r_psum + opnd_p;
                    n_wsum  = r_wsum + psum_w + opnd_w;
                end
                KIND_PUSH_REAR: begin
                    n_count = r_count + CNT_W'(1);
                    n_psum  = r_psum + opnd_p;
                    n_wsum  = r_wsum + r_prod;
                end
                KIND_POP_FRONT: begin
                    // every remaining entry moves forward one place
                    n_head  = (r_head == LAST_IDX) ? '0 : (r_head + IDX_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_psum  = r_psum - opnd_p;
                    n_wsum  = r_wsum - psum_w;
                end
                KIND_POP_REAR: begin
                    n_count = r_count - CNT_W'(1);
                    n_psum  = r_psum - opnd_p;
                    n_wsum  = r_wsum - r_prod;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign pop_sel  = (!r_err && is_pop) ? r_opnd : '0;
    assign pop_wide = RAW_W'(pop_sel);
    assign cnt_wide = CNTO_W'(n_count);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_psum  <= '0;
            r_wsum  <= '0;
        end else if (i_cmd.update) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_psum  <= n_psum;
            r_wsum  <= n_wsum;
        end
    end

    // payload registers and memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_in.kind;
            r_val   <= in_val;
            r_err   <= in_err;
            r_slot  <= in_slot;
            r_rdata <= r_mem[in_slot];
        end
        if (i_cmd.calc) begin
            r_opnd <= opnd;
            r_prod <= WDQ_WSUM_W'(mul_p);
        end
        if (i_cmd.update) begin
            if (!r_err && !is_pop) begin
                r_mem[r_slot] <= r_val;
            end
            r_out.popped_value <= pop_wide[WDQ_POP_W-1:0];
            r_out.weighted_sum <= n_wsum;
            r_out.entry_count  <= cnt_wide[WDQ_COUNT_W-1:0];
            r_out.is_empty     <= (n_count == '0);
            r_out.error_flag   <= r_err;
        end
    end

    assign o_out = r_out;

    `WDQ_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= FULL_CNT)
    `WDQ_ASSERT_IMP(a_empty_psum, i_clk, i_rst_n, r_count == '0, r_psum == '0 && r_wsum == '0)

endmodule

`default_nettype wire

// File: tb/weighted_deque_tb.sv
// self-checking testbench for weighted_deque: predictor, scoreboard and random handshakes
`timescale 1ns / 100ps

module weighted_deque_tb;
    import wdq_pkg::*;

    localparam int DEPTH      = WDQ_DEPTH_DEF;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int IDLE_LIMIT = 1000;   // cycles with no beat moving on either side
    localparam int MAX_SHOWN  = 10;
    localparam int DRAIN_WAIT = 8;      // wait after the last expected result is checked

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_stall;
    t_wdq_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_wdq_out o_out_data;

    weighted_deque u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // deque predictor: ring of values, front index, count, both sums
    // ---------------------------------------------------------------
    logic signed [WDQ_VALUE_W-1:0] ring_mem [DEPTH];
    logic [IDX_W-1:0]              front_idx  = '0;
    logic [WDQ_COUNT_W-1:0]        fill_cnt   = '0;
    logic signed [21:0]            run_sum    = '0;
    logic signed [WDQ_WSUM_W-1:0]  wsum       = '0;
    t_wdq_out                      deque_results [$];

    int mismatches   = 0;
    int stuck_cycles = 0;
    int stall_left   = 0;
    bit in_idle_on   = 1'b1;
    bit out_idle_on  = 1'b1;

    // apply one beat to the predicted deque and return the result it gives
    function automatic t_wdq_out deque_step(t_wdq_in beat);
        t_wdq_out                      res;
        logic [IDX_W-1:0]              slot;
        logic signed [WDQ_VALUE_W-1:0] v;
        v   = beat.value;
        res = '0;
        if (beat.kind == KIND_PUSH_FRONT || beat.kind == KIND_PUSH_REAR) begin
            if (fill_cnt >= DEPTH) begin
                // push on full is dropped
                res.error_flag = 1'b1;
            end else if (beat.kind == KIND_PUSH_FRONT) begin
                // every held entry moves one position back
                front_idx           = front_idx - 1'b1;
                ring_mem[front_idx] = v;
                wsum                = wsum + run_sum + v;
                run_sum             = run_sum + v;
                fill_cnt            = fill_cnt + 1'b1;
            end else begin
                slot           = front_idx + fill_cnt[IDX_W-1:0];
                ring_mem[slot] = v;
                fill_cnt       = fill_cnt + 1'b1;
                wsum           = wsum + $signed({1'b0, fill_cnt}) * v;
                run_sum        = run_sum + v;
            end
        end else begin
            if (fill_cnt == 0) begin
                // pop on empty returns zero
                res.error_flag = 1'b1;
            end else if (beat.kind == KIND_POP_FRONT) begin
                res.popped_value = ring_mem[front_idx];
                wsum             = wsum - run_sum;
                run_sum          = run_sum - res.popped_value;
                front_idx        = front_idx + 1'b1;
                fill_cnt         = fill_cnt - 1'b1;
            end else begin
                slot             = front_idx + fill_cnt[IDX_W-1:0] - 1'b1;
                res.popped_value = ring_mem[slot];
                wsum             = wsum - $signed({1'b0, fill_cnt}) * res.popped_value;
                run_sum          = run_sum - res.popped_value;
                fill_cnt         = fill_cnt - 1'b1;
            end
        end
        res.weighted_sum = wsum;
        res.entry_count  = fill_cnt;
        res.is_empty     = (fill_cnt == 0);
        return res;
    endfunction

    // scoreboard: predict on each input beat, check each result beat
    always @(posedge i_clk) begin : scoreboard
        t_wdq_out want;
        bit       bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (deque_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: result beat with nothing expected: %p", $time, o_out_data);
            end else begin
                want = deque_results.pop_front();
                bad  = (o_out_data.popped_value !== want.popped_value)
                    || (o_out_data.weighted_sum !== want.weighted_sum)
                    || (o_out_data.entry_count  !== want.entry_count)
                    || (o_out_data.is_empty     !== want.is_empty)
                    || (o_out_data.error_flag   !== want.error_flag);
                if (bad) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN) begin
                        $write("%0t: mismatch (exp/act) pop=%0d/%0d wsum=%0d/%0d",
                               $time, want.popped_value, o_out_data.popped_value,
                               want.weighted_sum, o_out_data.weighted_sum);
                        $display(" cnt=%0d/%0d empty=%0b/%0b err=%0b/%0b",
                                 want.entry_count, o_out_data.entry_count,
                                 want.is_empty, o_out_data.is_empty,
                                 want.error_flag, o_out_data.error_flag);
                    end
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            deque_results.push_back(deque_step(i_in_data));
    end

    // watchdog on cycles where no beat moves
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (out_idle_on && $urandom_range(0, 99) < 25) begin
            i_out_stall <= 1'b1;
            stall_left  <= pick_gap_len() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // extremes often, otherwise any 16-bit pattern
    function automatic logic signed [WDQ_VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'sh7fff;
        else if (r < 20)
            return 16'sh8000;
        else if (r < 25)
            return '0;
        else if (r < 30)
            return '1;
        return WDQ_VALUE_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [WDQ_KIND_W-1:0] rand_push();
        return $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
    endfunction

    function automatic logic [WDQ_KIND_W-1:0] rand_pop();
        return $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
    endfunction

    // send one input beat; valid stays high afterward unless the next beat idles first
    task automatic send_beat(input logic [WDQ_KIND_W-1:0] kind,
                             input logic signed [WDQ_VALUE_W-1:0] value);
        int gap;
        gap = (in_idle_on && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= t_wdq_in'{kind, value};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // empty pops, extremes at both ends, mixed order pops
    task automatic test_directed();
        send_beat(KIND_POP_FRONT, 16'sh1234);
        send_beat(KIND_POP_REAR, 16'sh4321);
        send_beat(KIND_PUSH_FRONT, 16'sh7fff);
        send_beat(KIND_PUSH_REAR, 16'sh8000);
        send_beat(KIND_PUSH_FRONT, -16'sd1);
        send_beat(KIND_PUSH_REAR, 16'sd1);
        send_beat(KIND_PUSH_FRONT, 16'sd0);
        send_beat(KIND_POP_FRONT, 16'sh7fff);
        send_beat(KIND_POP_REAR, 16'sh8000);
        send_beat(KIND_POP_FRONT, '0);
        send_beat(KIND_POP_REAR, '1);
        send_beat(KIND_POP_FRONT, 16'sh5555);
        send_beat(KIND_POP_REAR, 16'shaaaa);
        send_beat(KIND_PUSH_REAR, 16'sh5555);
        send_beat(KIND_PUSH_REAR, 16'shaaaa);
        send_beat(KIND_PUSH_FRONT, 16'sd123);
        send_beat(KIND_POP_REAR, '0);
        send_beat(KIND_POP_FRONT, '0);
        send_beat(KIND_POP_FRONT, '0);
        send_beat(KIND_POP_FRONT, '0);
    endtask

    // fill to full, push on full, drain to empty, pop on empty
    task automatic test_fill_drain(input logic signed [WDQ_VALUE_W-1:0] fill_val);
        repeat (DEPTH) send_beat(rand_push(), fill_val);
        repeat (2) send_beat(rand_push(), rand_value());
        repeat (DEPTH) send_beat(rand_pop(), rand_value());
        send_beat(rand_pop(), rand_value());
    endtask

    // random walk with push bias and idling changed every segment
    task automatic test_random_walk(input int n_beats);
        int push_pct;
        push_pct = 50;
        for (int i = 0; i < n_beats; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < push_pct)
                send_beat(rand_push(), rand_value());
            else
                send_beat(rand_pop(), rand_value());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        in_idle_on = 1'b0;
        test_fill_drain(16'sh7fff);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b0;
        test_fill_drain(16'sh8000);
        out_idle_on = 1'b1;
        test_random_walk(420);

        i_in_valid <= 1'b0;
        while (deque_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && deque_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/wdq_pkg.sv
rtl/core/wdq_ctrl.sv
rtl/core/wdq_dpath.sv
rtl/core/weighted_deque.sv
tb/weighted_deque_tb.sv
